// ===== hdl/scanline_detect_irq_timer_top_assert.svh =====
// Assertion macros shared by the checker file of the scanline detector.
// Each macro expects clk and rst to be visible where it is used.
`ifndef SCANLINE_DETECT_IRQ_TIMER_TOP_ASSERT_SVH
`define SCANLINE_DETECT_IRQ_TIMER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SDIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SDIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sdit_pkg.sv =====
`timescale 1ns / 1ps

package sdit_pkg;

  // Request operation codes
  localparam logic [2:0] OP_VIDEO_READ   = 3'd0;
  localparam logic [2:0] OP_CPU_TICK     = 3'd1;
  localparam logic [2:0] OP_STATUS_READ  = 3'd2;
  localparam logic [2:0] OP_TIMER_STATUS = 3'd3;
  localparam logic [2:0] OP_TIMER_LOW    = 3'd4;
  localparam logic [2:0] OP_TIMER_HIGH   = 3'd5;
  localparam logic [2:0] OP_RENDER_CTRL  = 3'd6;

  // Configuration register indexes
  localparam logic REG_IRQ_TARGET = 1'b0;
  localparam logic REG_IRQ_ENABLE = 1'b1;

  // Frame timing constants
  localparam logic [7:0] LAST_LINE  = 8'd240;
  localparam logic [7:0] IDLE_LIMIT = 8'd3;
  localparam logic [7:0] MATCH_MARK = 8'd2;

  // Name-table window 0x2000-0x2FFF: top two address bits are 2'b10
  localparam logic [1:0] NT_WINDOW = 2'b10;

  // One result as held in the output buffer
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       in_frame;
    logic [7:0] scanline;
  } result_t;

endpackage

// ===== hdl/scanline_detect_irq_timer_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   item_valid / item_stall   operation, address, data_value, vector_fetch
// result    result_valid / result_stall  read_data, irq_line, in_frame, scanline
// config    cfg_write                 cfg_index, cfg_data
//
// One request per clock while item_stall is low; its result is registered into the result register, or into the skid.
// All state updates sit in one combinational pass ahead of the state registers.
// A two-entry output buffer (result register plus skid) lets a request be taken
// while a result waits; item_stall rises only when both entries are full.
// rst (synchronous) clears all state, configuration and both buffer valid flags; the payload is not reset.

module scanline_detect_irq_timer_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  operation,
  input  logic [13:0] address,
  input  logic [7:0]  data_value,
  input  logic        vector_fetch,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_data,
  output logic        irq_line,
  output logic        in_frame,
  output logic [7:0]  scanline,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration
  logic [7:0]  irq_target;
  logic        irq_enable;

  // Detector and timer state
  logic        frame_active,     frame_active_next;
  logic        read_seen,        read_seen_next;
  logic        prev_hit,         prev_hit_next;
  logic [11:0] prev_low,         prev_low_next;
  logic [7:0]  match_run,        match_run_next;
  logic [7:0]  line_count,       line_count_next;
  logic        line_irq_pending, line_irq_pending_next;
  logic [7:0]  idle_cycles,      idle_cycles_next;
  logic        timer_active,     timer_active_next;
  logic        timer_flag,       timer_flag_next;
  logic [15:0] timer_value,      timer_value_next;

  // Output buffer
  sdit_pkg::result_t out_reg, skid_reg, result_next;
  logic              skid_valid;

  logic        accept;
  logic        out_take;
  logic        addr_in_window;
  logic        addr_match;
  logic [7:0]  line_inc;
  logic [7:0]  idle_inc;
  logic [15:0] timer_dec;
  logic [7:0]  rd;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_take   = result_valid && !result_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_target <= 8'd0;
      irq_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sdit_pkg::REG_IRQ_TARGET: irq_target <= cfg_data;
        sdit_pkg::REG_IRQ_ENABLE: irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign addr_in_window = (address[13:12] == sdit_pkg::NT_WINDOW);
  assign addr_match     = addr_in_window && prev_hit && (address[11:0] == prev_low);
  assign line_inc       = line_count + 8'd1;
  assign idle_inc       = idle_cycles + 8'd1;
  assign timer_dec      = timer_value - 16'd1;

  // Next-state logic for one request
  always_comb begin
    frame_active_next     = frame_active;
    read_seen_next        = read_seen;
    prev_hit_next         = prev_hit;
    prev_low_next         = prev_low;
    match_run_next        = match_run;
    line_count_next       = line_count;
    line_irq_pending_next = line_irq_pending;
    idle_cycles_next      = idle_cycles;
    timer_active_next     = timer_active;
    timer_flag_next       = timer_flag;
    timer_value_next      = timer_value;
    rd                    = 8'd0;

    if (vector_fetch) begin
      // vector fetch: leave frame and clear the scanline interrupt
      frame_active_next     = 1'b0;
      prev_hit_next         = 1'b0;
      line_irq_pending_next = 1'b0;
      line_count_next       = 8'd0;
    end else begin
      unique case (operation)
        sdit_pkg::OP_VIDEO_READ: begin
          if (addr_match) begin
            match_run_next = match_run + 8'd1;
          end else begin
            match_run_next = 8'd0;
            // run of three identical reads just ended: scanline mark
            if (match_run == sdit_pkg::MATCH_MARK) begin
              if (!frame_active) begin
                frame_active_next = 1'b1;
                line_count_next   = 8'd0;
              end else begin
                line_count_next = line_inc;
                if (line_inc == irq_target) begin
                  line_irq_pending_next = 1'b1;
                end
                if (line_inc == sdit_pkg::LAST_LINE) begin
                  frame_active_next     = 1'b0;
                  line_irq_pending_next = 1'b0;
                  line_count_next       = 8'd0;
                end
              end
            end
          end
          // out-of-window addresses never match, so prev_hit records whether the read was in the window
          prev_hit_next  = addr_in_window;
          prev_low_next  = address[11:0];
          read_seen_next = 1'b1;
        end
        sdit_pkg::OP_CPU_TICK: begin
          if (read_seen) begin
            idle_cycles_next = 8'd0;
          end else begin
            idle_cycles_next = idle_inc;
            if ((idle_inc == sdit_pkg::IDLE_LIMIT) && frame_active) begin
              frame_active_next = 1'b0;
              prev_hit_next     = 1'b0;
            end
          end
          read_seen_next = 1'b0;
          if (timer_active) begin
            timer_value_next = timer_dec;
            if (timer_dec == 16'd0) begin
              timer_flag_next = 1'b1;
            end
          end
        end
        sdit_pkg::OP_STATUS_READ: begin
          rd                    = {line_irq_pending, frame_active, 6'd0};
          line_irq_pending_next = 1'b0;
        end
        sdit_pkg::OP_TIMER_STATUS: begin
          rd              = {timer_flag, 7'd0};
          timer_flag_next = 1'b0;
        end
        sdit_pkg::OP_TIMER_LOW: begin
          timer_value_next  = {timer_value[15:8], data_value};
          timer_active_next = 1'b1;
        end
        sdit_pkg::OP_TIMER_HIGH: begin
          timer_value_next = {data_value, timer_value[7:0]};
        end
        sdit_pkg::OP_RENDER_CTRL: begin
          // rendering off (bits 3 and 4 clear) leaves the frame
          if ((data_value[4:3] == 2'b00) && frame_active) begin
            frame_active_next = 1'b0;
            prev_hit_next     = 1'b0;
          end
        end
        default: ;
      endcase
    end

    result_next.read_data = rd;
    result_next.irq_line  = (line_irq_pending_next && irq_enable) || timer_flag_next;
    result_next.in_frame  = frame_active_next;
    result_next.scanline  = line_count_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active     <= 1'b0;
      read_seen        <= 1'b0;
      prev_hit         <= 1'b0;
      prev_low         <= 12'd0;
      match_run        <= 8'd0;
      line_count       <= 8'd0;
      line_irq_pending <= 1'b0;
      idle_cycles      <= 8'd0;
      timer_active     <= 1'b0;
      timer_flag       <= 1'b0;
      timer_value      <= 16'd0;
    end else if (accept) begin
      frame_active     <= frame_active_next;
      read_seen        <= read_seen_next;
      prev_hit         <= prev_hit_next;
      prev_low         <= prev_low_next;
      match_run        <= match_run_next;
      line_count       <= line_count_next;
      line_irq_pending <= line_irq_pending_next;
      idle_cycles      <= idle_cycles_next;
      timer_active     <= timer_active_next;
      timer_flag       <= timer_flag_next;
      timer_value      <= timer_value_next;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (result_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (result_valid && !out_take) begin
        skid_reg <= result_next;
      end else begin
        out_reg <= result_next;
      end
    end
  end

  assign read_data = out_reg.read_data;
  assign irq_line  = out_reg.irq_line;
  assign in_frame  = out_reg.in_frame;
  assign scanline  = out_reg.scanline;

endmodule

// ===== hdl/sdit_checker.sv =====
`timescale 1ns / 1ps
`include "scanline_detect_irq_timer_top_assert.svh"

module sdit_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        vector_fetch,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  read_data,
  input logic        irq_line,
  input logic        in_frame,
  input logic [7:0]  scanline
);

  logic        open_empty;
  logic        into_empty;
  logic        vec_take;
  logic        low_clear;
  logic        left_frame;
  logic        stalled;
  logic [17:0] payload;

  // Request taken while the result side is empty
  assign open_empty = !result_valid && !item_stall;
  assign into_empty = item_valid && !item_stall && !result_valid;
  assign vec_take   = into_empty && vector_fetch;
  assign low_clear  = (read_data[5:0] == 6'd0);
  assign left_frame = !in_frame && (scanline == 8'd0);
  assign stalled    = result_valid && result_stall;
  assign payload    = {read_data, irq_line, in_frame, scanline};

  // Buffer comes out of reset empty and open
  `SDIT_ASSERT_NOW(a_reset_empty, $past(rst), open_empty, "buffer not empty after reset")

  // A request taken into an empty buffer shows its result next cycle
  `SDIT_ASSERT_NEXT(a_result_next, into_empty, result_valid && low_clear, "result missing")

  // A vector fetch taken into an empty buffer leaves the frame with the line count cleared
  `SDIT_ASSERT_NEXT(a_vector_leave, vec_take, left_frame, "vector fetch kept frame")

  // A stalled result holds
  `SDIT_ASSERT_NEXT(a_stall_hold, stalled, result_valid && $stable(payload), "stalled result moved")

endmodule

bind scanline_detect_irq_timer_top sdit_checker u_sdit_checker (.*);
